// ----- src/rgbhsv_pkg.sv -----
`default_nettype none

package rgbhsv_pkg;

    // field widths
    localparam int CHAN_W = 8;
    localparam int HUE_W  = 15;
    localparam int PCT_W  = 15;

    // scale constants
    localparam int HUE_SECTOR = 3840;   // 60 degrees in 1/64 degree
    localparam int HUE_TURN   = 23040;  // 360 degrees in 1/64 degree
    localparam int PCT_FULL   = 25600;  // 100 percent in 1/256 percent
    localparam int PCT_SCALE  = 100;

    // sector base angles
    localparam logic [HUE_W-1:0] BASE_RED      = HUE_W'(0);
    localparam logic [HUE_W-1:0] BASE_RED_WRAP = HUE_W'(HUE_TURN);
    localparam logic [HUE_W-1:0] BASE_GREEN    = HUE_W'(2 * HUE_SECTOR);
    localparam logic [HUE_W-1:0] BASE_BLUE     = HUE_W'(4 * HUE_SECTOR);

    // divider geometry
    localparam int DIV_NUM_W = 23;
    localparam int DIV_DEN_W = CHAN_W;
    localparam int HUE_Q_W   = 13;

    // per pixel data that bypasses the dividers
    typedef struct packed {
        logic [HUE_W-1:0] hue_base;
        logic             hue_neg;
        logic             hue_valid;
        logic             sat_zero;
        logic [PCT_W-1:0] brightness;
    } side_t;

    // one classified pixel, handed from front to back
    typedef struct packed {
        logic [DIV_NUM_W-1:0] hue_num;
        logic [DIV_DEN_W-1:0] hue_den;
        logic [DIV_NUM_W-1:0] sat_num;
        logic [DIV_DEN_W-1:0] sat_den;
        side_t                side;
    } job_t;

    // queue status
    typedef struct packed {
        logic full;
        logic empty;
    } fifo_stat_t;

endpackage

`default_nettype wire

// ----- src/rgbhsv_if.sv -----
`default_nettype none

interface rgbhsv_rgb_if;
    logic                           valid;
    logic                           ready;
    logic [rgbhsv_pkg::CHAN_W-1:0]  red;
    logic [rgbhsv_pkg::CHAN_W-1:0]  green;
    logic [rgbhsv_pkg::CHAN_W-1:0]  blue;

    modport source (output valid, output red, output green, output blue, input ready);
    modport sink (input valid, input red, input green, input blue, output ready);
endinterface

interface rgbhsv_hsv_if;
    logic                          valid;
    logic                          ready;
    logic [rgbhsv_pkg::HUE_W-1:0]  hue;
    logic                          hue_valid;
    logic [rgbhsv_pkg::PCT_W-1:0]  saturation;
    logic [rgbhsv_pkg::PCT_W-1:0]  brightness;

    modport source (output valid, output hue, output hue_valid, output saturation,
                    output brightness, input ready);
    modport sink (input valid, input hue, input hue_valid, input saturation,
                  input brightness, output ready);
endinterface

`default_nettype wire

// ----- src/rgb_to_hsv_converter.sv -----
`default_nettype none

// channel   dir   payload                                   handshake
// rgb       in    red[7:0] green[7:0] blue[7:0]             valid/ready
// hsv       out   hue[14:0] hue_valid saturation[14:0]      valid/ready
//                 brightness[14:0]
//
// one pixel per clock sustained while the output is not stalled; from acceptance to
// result a pixel passes one classify stage, one queue slot, 23 divider stages and one
// output register. the 23-stage pipelined restoring dividers set the latency.
// rst_n clears valid bits and queue pointers at once; no clearing pass.
// a stalled output freezes the divider pipe; the queue and classify stage
// keep accepting until the queue fills.

module rgb_to_hsv_converter #(
    parameter int QUEUE_DEPTH = 4
) (
    input  wire logic      clk,
    input  wire logic      rst_n,
    rgbhsv_rgb_if.sink     rgb,
    rgbhsv_hsv_if.source   hsv
);

    rgbhsv_pkg::fifo_stat_t stat;
    rgbhsv_pkg::job_t       push_job;
    rgbhsv_pkg::job_t       pop_job;
    logic                   push;
    logic                   pop;

    // classify pixels
    rgbhsv_front u_front (
        .clk   (clk),
        .rst_n (rst_n),
        .rgb   (rgb),
        .stat  (stat),
        .push  (push),
        .job   (push_job)
    );

    // decoupling queue
    rgbhsv_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_job),
        .pop       (pop),
        .pop_data  (pop_job),
        .stat      (stat)
    );

    // divide and assemble results
    rgbhsv_back u_back (
        .clk   (clk),
        .rst_n (rst_n),
        .stat  (stat),
        .job   (pop_job),
        .pop   (pop),
        .hsv   (hsv)
    );

endmodule

`default_nettype wire

// ----- src/rgbhsv_front.sv -----
`default_nettype none

module rgbhsv_front (
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    rgbhsv_rgb_if.sink                   rgb,
    input  wire rgbhsv_pkg::fifo_stat_t  stat,
    output logic                         push,
    output rgbhsv_pkg::job_t             job
);

    localparam int CW = rgbhsv_pkg::CHAN_W;
    localparam int HW = rgbhsv_pkg::HUE_W;
    localparam int PW = rgbhsv_pkg::PCT_W;
    localparam int NW = rgbhsv_pkg::DIV_NUM_W;

    logic             valid_reg;
    logic             valid_next;
    rgbhsv_pkg::job_t job_reg;
    rgbhsv_pkg::job_t job_next;
    logic             accept;

    logic [CW-1:0]    mx;
    logic [CW-1:0]    mn;
    logic [CW-1:0]    delta;
    logic signed [CW:0] diff;
    logic [CW-1:0]    abs_diff;
    logic             neg;
    logic [HW-1:0]    base;
    logic [PW-1:0]    scaled;
    logic [PW:0]      frac_sum;
    logic [PW-1:0]    bright;

    // handshake: hold one classified pixel until the queue takes it
    assign push   = valid_reg && !stat.full;
    assign rgb.ready = !valid_reg || !stat.full;
    assign accept = rgb.valid && rgb.ready;
    assign job    = job_reg;

    // largest and smallest channel
    always_comb
    begin
        mx = rgb.red;
        mn = rgb.red;
        if (rgb.green > mx)
        begin
            mx = rgb.green;
        end
        if (rgb.blue > mx)
        begin
            mx = rgb.blue;
        end
        if (rgb.green < mn)
        begin
            mn = rgb.green;
        end
        if (rgb.blue < mn)
        begin
            mn = rgb.blue;
        end
        delta = mx - mn;
    end

    // sector pick, red wins ties then green
    always_comb
    begin
        if (rgb.red >= mx)
        begin
            diff = $signed({1'b0, rgb.green}) - $signed({1'b0, rgb.blue});
        end
        else if (rgb.green >= mx)
        begin
            diff = $signed({1'b0, rgb.blue}) - $signed({1'b0, rgb.red});
        end
        else
        begin
            diff = $signed({1'b0, rgb.red}) - $signed({1'b0, rgb.green});
        end
        neg      = diff[CW];
        abs_diff = neg ? CW'(-diff) : diff[CW-1:0];
        if (rgb.red >= mx)
        begin
            base = neg ? rgbhsv_pkg::BASE_RED_WRAP : rgbhsv_pkg::BASE_RED;
        end
        else if (rgb.green >= mx)
        begin
            base = rgbhsv_pkg::BASE_GREEN;
        end
        else
        begin
            base = rgbhsv_pkg::BASE_BLUE;
        end
    end

    // brightness = 100*max + floor(100*max/255), reciprocal form of the /255
    always_comb
    begin
        scaled   = PW'(mx) * PW'(rgbhsv_pkg::PCT_SCALE);
        frac_sum = (PW+1)'(scaled) + (PW+1)'(scaled >> 8) + (PW+1)'(1);
        bright   = scaled + PW'(frac_sum >> 8);
    end

    // assemble the transaction for the back end
    always_comb
    begin
        job_next                 = job_reg;
        job_next.hue_num         = NW'(abs_diff) * NW'(rgbhsv_pkg::HUE_SECTOR);
        job_next.hue_den         = delta;
        job_next.sat_num         = NW'(delta) * NW'(rgbhsv_pkg::PCT_FULL);
        job_next.sat_den         = mx;
        job_next.side.hue_base   = base;
        job_next.side.hue_neg    = neg;
        job_next.side.hue_valid  = (delta != '0);
        job_next.side.sat_zero   = (mx == '0);
        job_next.side.brightness = bright;
    end

    always_comb
    begin
        valid_next = valid_reg;
        if (accept)
        begin
            valid_next = 1'b1;
        end
        else if (push)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            job_reg <= job_next;
        end
    end

endmodule

`default_nettype wire

// ----- src/rgbhsv_fifo.sv -----
`default_nettype none

module rgbhsv_fifo #(
    parameter int DEPTH = 4
) (
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire logic                    push,
    input  wire rgbhsv_pkg::job_t        push_data,
    input  wire logic                    pop,
    output rgbhsv_pkg::job_t             pop_data,
    output rgbhsv_pkg::fifo_stat_t       stat
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    rgbhsv_pkg::job_t  mem_reg [DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg;
    logic [PTR_W-1:0]  wr_ptr_next;
    logic [PTR_W-1:0]  rd_ptr_reg;
    logic [PTR_W-1:0]  rd_ptr_next;
    logic [CNT_W-1:0]  count_reg;
    logic [CNT_W-1:0]  count_next;

    assign stat.full  = (count_reg == CNT_W'(DEPTH));
    assign stat.empty = (count_reg == '0);
    assign pop_data   = mem_reg[rd_ptr_reg];

    // pointer wrap and fill count
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        if (push && !pop)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

`ifndef NO_ASSERTIONS
    // the fill count never passes the depth
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(DEPTH))
        else $error("queue count beyond depth");
`endif

endmodule

`default_nettype wire

// ----- src/rgbhsv_div.sv -----
`default_nettype none

module rgbhsv_div (
    input  wire logic                               clk,
    input  wire logic                               en,
    input  wire logic [rgbhsv_pkg::DIV_NUM_W-1:0]   num,
    input  wire logic [rgbhsv_pkg::DIV_DEN_W-1:0]   den,
    output logic [rgbhsv_pkg::DIV_NUM_W-1:0]        quo,
    output logic [rgbhsv_pkg::DIV_DEN_W-1:0]        rem
);

    localparam int N = rgbhsv_pkg::DIV_NUM_W;
    localparam int D = rgbhsv_pkg::DIV_DEN_W;

    logic [N-1:0] num_reg [N];
    logic [N-1:0] quo_reg [N];
    logic [D-1:0] rem_reg [N];
    logic [D-1:0] den_reg [N];

    assign quo = quo_reg[N-1];
    assign rem = rem_reg[N-1];

    // one restoring step per stage, quotient msb first
    for (genvar s = 0; s < N; s++)
    begin : g_stage
        logic [N-1:0] num_in;
        logic [N-1:0] quo_in;
        logic [D-1:0] rem_in;
        logic [D-1:0] den_in;
        logic [D:0]   part;
        logic [D:0]   diff;
        logic         ge;

        if (s == 0)
        begin : g_first
            assign num_in = num;
            assign quo_in = '0;
            assign rem_in = '0;
            assign den_in = den;
        end
        else
        begin : g_next
            assign num_in = num_reg[s-1];
            assign quo_in = quo_reg[s-1];
            assign rem_in = rem_reg[s-1];
            assign den_in = den_reg[s-1];
        end

        always_comb
        begin
            part = {rem_in, num_in[N-1]};
            diff = part - {1'b0, den_in};
            ge   = (part >= {1'b0, den_in});
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                num_reg[s] <= {num_in[N-2:0], 1'b0};
                quo_reg[s] <= {quo_in[N-2:0], ge};
                rem_reg[s] <= ge ? diff[D-1:0] : part[D-1:0];
                den_reg[s] <= den_in;
            end
        end
    end

endmodule

`default_nettype wire

// ----- src/rgbhsv_back.sv -----
`default_nettype none

module rgbhsv_back (
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire rgbhsv_pkg::fifo_stat_t  stat,
    input  wire rgbhsv_pkg::job_t        job,
    output logic                         pop,
    rgbhsv_hsv_if.source                 hsv
);

    localparam int N  = rgbhsv_pkg::DIV_NUM_W;
    localparam int D  = rgbhsv_pkg::DIV_DEN_W;
    localparam int HW = rgbhsv_pkg::HUE_W;
    localparam int PW = rgbhsv_pkg::PCT_W;
    localparam int QW = rgbhsv_pkg::HUE_Q_W;

    logic                   advance;
    logic [N-1:0]           vld_reg;
    logic                   out_valid_reg;
    rgbhsv_pkg::side_t      side_reg [N];
    logic [N-1:0]           hue_quo;
    logic [D-1:0]           hue_rem;
    logic [N-1:0]           sat_quo;
    logic [D-1:0]           sat_rem;
    rgbhsv_pkg::side_t      side_end;
    logic [QW-1:0]          frac;
    logic [HW-1:0]          hue_next;
    logic                   hue_valid_next;
    logic [PW-1:0]          sat_next;
    logic [HW-1:0]          hue_reg;
    logic                   hue_valid_reg;
    logic [PW-1:0]          sat_reg;
    logic [PW-1:0]          bright_reg;

    // the whole pipe moves unless a finished result is held
    assign advance = !out_valid_reg || hsv.ready;
    assign pop     = advance && !stat.empty;

    assign hsv.valid      = out_valid_reg;
    assign hsv.hue        = hue_reg;
    assign hsv.hue_valid  = hue_valid_reg;
    assign hsv.saturation = sat_reg;
    assign hsv.brightness = bright_reg;

    // hue fraction 3840*|diff|/delta
    rgbhsv_div u_hue_div (
        .clk (clk),
        .en  (advance),
        .num (job.hue_num),
        .den (job.hue_den),
        .quo (hue_quo),
        .rem (hue_rem)
    );

    // saturation 25600*delta/max
    rgbhsv_div u_sat_div (
        .clk (clk),
        .en  (advance),
        .num (job.sat_num),
        .den (job.sat_den),
        .quo (sat_quo),
        .rem (sat_rem)
    );

    // sideband delay matched to the dividers
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            side_reg[0] <= job.side;
            for (int i = 1; i < N; i++)
            begin
                side_reg[i] <= side_reg[i-1];
            end
        end
    end

    assign side_end = side_reg[N-1];

    // fold the quotient into the sector, rounding up on the negative side
    always_comb
    begin
        frac = hue_quo[QW-1:0] + QW'(side_end.hue_neg && (hue_rem != '0));
        if (!side_end.hue_valid)
        begin
            hue_next = '0;
        end
        else if (side_end.hue_neg)
        begin
            hue_next = side_end.hue_base - HW'(frac);
        end
        else
        begin
            hue_next = side_end.hue_base + HW'(frac);
        end
        hue_valid_next = side_end.hue_valid;
        sat_next       = side_end.sat_zero ? '0 : sat_quo[PW-1:0];
    end

    // valid bits through the pipe
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            vld_reg       <= {vld_reg[N-2:0], pop};
            out_valid_reg <= vld_reg[N-1];
        end
    end

    // output register
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            hue_reg       <= hue_next;
            hue_valid_reg <= hue_valid_next;
            sat_reg       <= sat_next;
            bright_reg    <= side_end.brightness;
        end
    end

`ifndef NO_ASSERTIONS
    // a defined hue stays below a full turn
    a_hue_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && hue_valid_reg |-> hue_reg < HW'(rgbhsv_pkg::HUE_TURN))
        else $error("hue out of range");

    // an undefined hue reads as zero
    a_hue_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !hue_valid_reg |-> hue_reg == '0)
        else $error("undefined hue not zero");

    // percentages never exceed full scale
    a_pct_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> sat_reg <= PW'(rgbhsv_pkg::PCT_FULL)
                          && bright_reg <= PW'(rgbhsv_pkg::PCT_FULL))
        else $error("percentage out of range");

    // for a non-black pixel, the saturation remainder is below the low brightness byte or the brightness is non-zero
    a_sat_rem: assert property (@(posedge clk) disable iff (!rst_n)
        vld_reg[N-1] && !side_end.sat_zero |-> sat_rem < side_reg[N-1].brightness[D-1:0]
            || side_reg[N-1].brightness != '0)
        else $error("saturation divider remainder");
`endif

endmodule

`default_nettype wire
